// File: rtl/core/rgbhsv_pkg.sv
package rgbhsv_pkg;
  localparam int CHANNEL_BITS = 8;
  localparam int HUE_BITS = 16;
  localparam int SAT_BITS = 16;
  localparam int SNUM_BITS = CHANNEL_BITS + SAT_BITS;
  localparam int HNUM_BITS = CHANNEL_BITS + 3 + HUE_BITS;
  localparam int DEN_BITS = CHANNEL_BITS + 3;
  localparam int QUO_BITS = (SNUM_BITS > HNUM_BITS) ? SNUM_BITS : HNUM_BITS;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  typedef struct packed {
    logic [HNUM_BITS-1:0] hnum;
    logic [DEN_BITS-1:0]  hden;
    logic [SNUM_BITS-1:0] snum;
    chan_t                mx;
  } work_t;
endpackage

// File: rtl/core/rgbhsv_if.sv
interface rgbhsv_pix_if;
  logic valid;
  logic ready;
  logic [rgbhsv_pkg::CHANNEL_BITS-1:0] red;
  logic [rgbhsv_pkg::CHANNEL_BITS-1:0] green;
  logic [rgbhsv_pkg::CHANNEL_BITS-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface rgbhsv_hsv_if;
  logic valid;
  logic ready;
  logic [rgbhsv_pkg::HUE_BITS-1:0] hue;
  logic [rgbhsv_pkg::SAT_BITS-1:0] saturation;
  logic [rgbhsv_pkg::CHANNEL_BITS-1:0] brightness;
  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

// File: rtl/core/rgbhsv_front.sv
module rgbhsv_front (
  input  logic                      clk,
  input  logic                      rst,
  rgbhsv_pix_if.sink                pix,
  output logic                      wvalid,
  input  logic                      wready,
  output rgbhsv_pkg::work_t         wdata
);
  import rgbhsv_pkg::*;

  chan_t r, g, b, mx, mn, dl;
  logic signed [CHANNEL_BITS:0] n;
  logic [2:0] k;
  logic [DEN_BITS-1:0] num;
  work_t w;

  always_comb begin
    r = pix.red; g = pix.green; b = pix.blue;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl = mx - mn;
    if (mx == r) begin
      n = $signed({1'b0, g}) - $signed({1'b0, b});
      k = n[CHANNEL_BITS] ? 3'd6 : 3'd0;
    end else if (mx == g) begin
      n = $signed({1'b0, b}) - $signed({1'b0, r});
      k = 3'd2;
    end else begin
      n = $signed({1'b0, r}) - $signed({1'b0, g});
      k = 3'd4;
    end
    num = DEN_BITS'(k) * DEN_BITS'(dl) + DEN_BITS'(unsigned'(DEN_BITS'(n)));
    w.hnum = {num, HUE_BITS'(0)};
    w.hden = DEN_BITS'(dl) * DEN_BITS'(6);
    w.snum = (SNUM_BITS'(dl) << SAT_BITS) - SNUM_BITS'(dl);
    w.mx = mx;
  end

  assign pix.ready = !wvalid || wready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= 1'b0;
    end else if (pix.ready) begin
      wvalid <= pix.valid;
    end
    if (pix.ready && pix.valid) wdata <= w;
  end
endmodule

// File: rtl/core/rgbhsv_fifo.sv
module rgbhsv_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              ivalid,
  output logic              iready,
  input  rgbhsv_pkg::work_t idata,
  output logic              ovalid,
  input  logic              oready,
  output rgbhsv_pkg::work_t odata
);
  import rgbhsv_pkg::*;

  work_t mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wp, rp;
  logic [FIFO_CNT_BITS-1:0] cnt;
  logic push, pop;

  assign iready = cnt != FIFO_CNT_BITS'(FIFO_DEPTH);
  assign ovalid = cnt != '0;
  assign odata = mem[rp];
  assign push = ivalid && iready;
  assign pop = ovalid && oready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= (wp == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wp + FIFO_PTR_BITS'(1);
      if (pop) rp <= (rp == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rp + FIFO_PTR_BITS'(1);
      cnt <= cnt + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(pop);
    end
    if (push) mem[wp] <= idata;
  end
endmodule

// File: rtl/core/rgbhsv_back.sv
module rgbhsv_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              wvalid,
  output logic              wready,
  input  rgbhsv_pkg::work_t wdata,
  rgbhsv_hsv_if.source      hsv
);
  import rgbhsv_pkg::*;

  localparam int NSTG = QUO_BITS;

  // restoring dividers, one quotient bit per stage
  logic                  v   [NSTG+1];
  logic [HNUM_BITS-1:0]  hq  [NSTG+1];
  logic [DEN_BITS:0]     hr  [NSTG+1];
  logic [DEN_BITS-1:0]   hd  [NSTG+1];
  logic [SNUM_BITS-1:0]  sq  [NSTG+1];
  logic [CHANNEL_BITS:0] sr  [NSTG+1];
  chan_t                 sd  [NSTG+1];
  logic                  adv;

  assign adv = !hsv.valid || hsv.ready;
  assign wready = adv;

  always_comb begin
    v[0] = wvalid; hq[0] = wdata.hnum; hr[0] = '0; hd[0] = wdata.hden;
    sq[0] = wdata.snum; sr[0] = '0; sd[0] = wdata.mx;
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    logic [DEN_BITS+1:0] ht;
    logic [CHANNEL_BITS+1:0] st;
    always_comb begin
      ht = {hr[i], hq[i][HNUM_BITS-1]} - {2'b0, hd[i]};
      st = {sr[i], sq[i][SNUM_BITS-1]} - {2'b0, sd[i]};
    end
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else if (adv) v[i+1] <= v[i];
      if (adv) begin
        hd[i+1] <= hd[i]; sd[i+1] <= sd[i];
        if (i < HNUM_BITS) begin
          hq[i+1] <= {hq[i][HNUM_BITS-2:0], !ht[DEN_BITS+1]};
          hr[i+1] <= ht[DEN_BITS+1] ? {hr[i][DEN_BITS-1:0], hq[i][HNUM_BITS-1]}
                                    : ht[DEN_BITS:0];
        end else begin
          hq[i+1] <= hq[i]; hr[i+1] <= hr[i];
        end
        if (i < SNUM_BITS) begin
          sq[i+1] <= {sq[i][SNUM_BITS-2:0], !st[CHANNEL_BITS+1]};
          sr[i+1] <= st[CHANNEL_BITS+1] ? {sr[i][CHANNEL_BITS-1:0], sq[i][SNUM_BITS-1]}
                                        : st[CHANNEL_BITS:0];
        end else begin
          sq[i+1] <= sq[i]; sr[i+1] <= sr[i];
        end
      end
    end
  end

  assign hsv.valid = v[NSTG];
  assign hsv.hue = (hd[NSTG] == '0) ? '0 : HUE_BITS'(hq[NSTG]);
  assign hsv.saturation = (sd[NSTG] == '0) ? '0 : SAT_BITS'(sq[NSTG]);
  assign hsv.brightness = sd[NSTG];
endmodule

// File: rtl/core/rgb_to_hsv_pixel.sv
// channel | role   | payload
// pix     | sink   | red, green, blue
// hsv     | source | hue, saturation, brightness
// one transaction per cycle sustained while hsv is ready; a pixel passes the front
// register, the fifo and one back stage per quotient bit (27 at default widths)
// of the bit-serial divider pipeline in the back part
// synchronous active-high reset empties all stages and the fifo
// an output stall freezes the divider pipeline; the fifo absorbs slack
module rgb_to_hsv_pixel (
  input logic          clk,
  input logic          rst,
  rgbhsv_pix_if.sink   pix,
  rgbhsv_hsv_if.source hsv
);
  import rgbhsv_pkg::*;

  logic fv, fr, qv, qr;
  work_t fd, qd;

  rgbhsv_front u_front (.clk, .rst, .pix, .wvalid(fv), .wready(fr), .wdata(fd));
  rgbhsv_fifo u_fifo (.clk, .rst, .ivalid(fv), .iready(fr), .idata(fd),
                      .ovalid(qv), .oready(qr), .odata(qd));
  rgbhsv_back u_back (.clk, .rst, .wvalid(qv), .wready(qr), .wdata(qd), .hsv);

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !hsv.valid |-> qr) else $error("back stalled without output");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    hsv.valid && !hsv.ready |=> hsv.valid) else $error("result lost");
  a_front: assert property (@(posedge clk) disable iff (rst)
    fv && !fr |=> fv) else $error("front item lost");
endmodule
